// ===== design/gdh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdh_pkg
// Shared widths, beat types and metric codes for the grid distance heuristic.
// ----------------------------------------------------------------------------
package gdh_pkg;

    // field widths
    localparam int COORD_WIDTH   = 16;
    localparam int FRAC_BITS     = 8;
    localparam int NUM_AXES      = 3;
    localparam int DIST_WIDTH    = COORD_WIDTH + FRAC_BITS + 2;

    // internal widths
    localparam int SQ_WIDTH      = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH     = 2 * COORD_WIDTH + 2;
    localparam int ABS_SUM_WIDTH = COORD_WIDTH + 2;
    localparam int ROOT_BITS     = SUM_WIDTH / 2 + FRAC_BITS;
    localparam int REM_WIDTH     = ROOT_BITS + 2;

    // mask over the fraction bits of a distance
    localparam logic [DIST_WIDTH-1:0] FRAC_MASK =
        DIST_WIDTH'((64'd1 << FRAC_BITS) - 64'd1);

    typedef enum logic
    {
        METRIC_EUCLID    = 1'b0,
        METRIC_MANHATTAN = 1'b1
    } metric_t;

    typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] point_t;

    // beat leaving the difference and square stages
    typedef struct packed
    {
        logic                     valid;
        metric_t                  mode;
        logic [ABS_SUM_WIDTH-1:0] sum_abs;
        logic [SUM_WIDTH-1:0]     sum_sq;
    } front_beat_t;

    // payload carried through one root stage
    typedef struct packed
    {
        metric_t                  mode;
        logic [ABS_SUM_WIDTH-1:0] sum_abs;
        logic [SUM_WIDTH-1:0]     rad;
        logic [REM_WIDTH-1:0]     rem;
        logic [ROOT_BITS-1:0]     root;
    } root_data_t;

    // beat leaving the root pipeline
    typedef struct packed
    {
        logic                     valid;
        metric_t                  mode;
        logic [ABS_SUM_WIDTH-1:0] sum_abs;
        logic [ROOT_BITS-1:0]     root;
    } root_beat_t;

endpackage
`default_nettype wire

// ===== design/gdh_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdh_front
// Three register stages: absolute axis differences, squares and abs sum,
// then the sum of squares.
// ----------------------------------------------------------------------------
module gdh_front
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   in_valid,
    input  gdh_pkg::metric_t      in_mode,
    input  gdh_pkg::point_t       first_pt,
    input  gdh_pkg::point_t       second_pt,
    output gdh_pkg::front_beat_t  beat
);
    import gdh_pkg::*;

    logic                                  valid_a_reg;
    logic                                  valid_b_reg;
    logic                                  valid_c_reg;
    metric_t                               mode_a_reg;
    metric_t                               mode_b_reg;
    metric_t                               mode_c_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  abs_next;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  abs_a_reg;
    logic [NUM_AXES-1:0][SQ_WIDTH-1:0]     sq_b_reg;
    logic [ABS_SUM_WIDTH-1:0]              abs_sum_next;
    logic [ABS_SUM_WIDTH-1:0]              abs_sum_b_reg;
    logic [ABS_SUM_WIDTH-1:0]              abs_sum_c_reg;
    logic [SUM_WIDTH-1:0]                  sum_sq_next;
    logic [SUM_WIDTH-1:0]                  sum_sq_c_reg;

    // absolute difference per axis, one extra bit for the subtract
    always_comb
    begin
        logic [COORD_WIDTH:0] diff;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            diff = {first_pt[k][COORD_WIDTH-1], first_pt[k]}
                 - {second_pt[k][COORD_WIDTH-1], second_pt[k]};
            if (diff[COORD_WIDTH])
                abs_next[k] = COORD_WIDTH'(~diff + 1'b1);
            else
                abs_next[k] = diff[COORD_WIDTH-1:0];
        end
    end

    // sum of absolute differences
    always_comb
    begin
        abs_sum_next = '0;
        for (int k = 0; k < NUM_AXES; k++)
            abs_sum_next = abs_sum_next + ABS_SUM_WIDTH'(abs_a_reg[k]);
    end

    // sum of squares
    always_comb
    begin
        sum_sq_next = '0;
        for (int k = 0; k < NUM_AXES; k++)
            sum_sq_next = sum_sq_next + SUM_WIDTH'(sq_b_reg[k]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_a_reg    <= in_mode;
            abs_a_reg     <= abs_next;
            mode_b_reg    <= mode_a_reg;
            abs_sum_b_reg <= abs_sum_next;
            for (int k = 0; k < NUM_AXES; k++)
                sq_b_reg[k] <= abs_a_reg[k] * abs_a_reg[k];
            mode_c_reg    <= mode_b_reg;
            abs_sum_c_reg <= abs_sum_b_reg;
            sum_sq_c_reg  <= sum_sq_next;
        end
    end

    assign beat.valid   = valid_c_reg;
    assign beat.mode    = mode_c_reg;
    assign beat.sum_abs = abs_sum_c_reg;
    assign beat.sum_sq  = sum_sq_c_reg;

endmodule
`default_nettype wire

// ===== design/gdh_root_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdh_root_pipe
// Restoring square root, one root bit per register stage, radicand pairs
// taken from the top; zero pairs shift in for the fraction bits.
// ----------------------------------------------------------------------------
module gdh_root_pipe
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  gdh_pkg::front_beat_t  in_beat,
    output gdh_pkg::root_beat_t   out_beat
);
    import gdh_pkg::*;

    logic [ROOT_BITS-1:0] valid_reg;
    root_data_t           stage_reg  [ROOT_BITS];
    root_data_t           stage_next [ROOT_BITS];
    root_data_t           stage_prev [ROOT_BITS];
    logic                 valid_prev [ROOT_BITS];

    // first stage starts from the summed squares
    assign stage_prev[0].mode    = in_beat.mode;
    assign stage_prev[0].sum_abs = in_beat.sum_abs;
    assign stage_prev[0].rad     = in_beat.sum_sq;
    assign stage_prev[0].rem     = '0;
    assign stage_prev[0].root    = '0;
    assign valid_prev[0]         = in_beat.valid;

    genvar k;
    generate
        for (k = 0; k < ROOT_BITS; k++)
        begin : g_stage
            if (k > 0)
            begin : g_link
                assign stage_prev[k] = stage_reg[k-1];
                assign valid_prev[k] = valid_reg[k-1];
            end

            // one trial subtract per stage
            always_comb
            begin
                logic [REM_WIDTH-1:0] rem_sh;
                logic [REM_WIDTH-1:0] trial;
                rem_sh = {stage_prev[k].rem[REM_WIDTH-3:0],
                          stage_prev[k].rad[SUM_WIDTH-1 -: 2]};
                trial  = {stage_prev[k].root, 2'b01};
                stage_next[k].mode    = stage_prev[k].mode;
                stage_next[k].sum_abs = stage_prev[k].sum_abs;
                stage_next[k].rad     = stage_prev[k].rad << 2;
                if (rem_sh >= trial)
                begin
                    stage_next[k].rem  = rem_sh - trial;
                    stage_next[k].root = {stage_prev[k].root[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    stage_next[k].rem  = rem_sh;
                    stage_next[k].root = {stage_prev[k].root[ROOT_BITS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (en)
                    valid_reg[k] <= valid_prev[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[k] <= stage_next[k];
            end
        end
    endgenerate

    assign out_beat.valid   = valid_reg[ROOT_BITS-1];
    assign out_beat.mode    = stage_reg[ROOT_BITS-1].mode;
    assign out_beat.sum_abs = stage_reg[ROOT_BITS-1].sum_abs;
    assign out_beat.root    = stage_reg[ROOT_BITS-1].root;

    // remainder of a finished root never exceeds twice the root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ROOT_BITS-1] |->
            (stage_reg[ROOT_BITS-1].rem
                <= REM_WIDTH'({stage_reg[ROOT_BITS-1].root, 1'b0})))
        else $error("root remainder out of bound");

    // every radicand pair has been consumed by the last stage
    a_rad_used: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ROOT_BITS-1] |-> (stage_reg[ROOT_BITS-1].rad == '0))
        else $error("radicand not fully consumed");

    // a beat taken in shows up in the first root stage in the next cycle
    a_pipe_len: assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_beat.valid) |=> (valid_reg[0]))
        else $error("root stage dropped a beat");

endmodule
`default_nettype wire

// ===== design/grid_distance_heuristic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grid_distance_heuristic
// Euclidean or Manhattan distance between two 3-D grid points, unsigned
// fixed point with FRAC_BITS fraction bits, Euclidean root truncated.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  input     in_valid, in_stall, first_*, second_*    in (in_stall out)
//  output    out_valid, out_stall, distance           out (out_stall in)
//  config    cfg_wr_en, cfg_wr_data (metric_mode)     in
//
//  One beat accepted per cycle while in_stall is low; a beat passes the front
//  stages, the one-bit-per-stage square root pipeline and the output register.
//  Reset clears all valid bits and sets the metric to Euclidean.
//  The whole pipeline holds while a result sits in the output register and
//  out_stall is high; in_stall follows that condition.
// ----------------------------------------------------------------------------
module grid_distance_heuristic
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_wr_en,
    input  wire                                   cfg_wr_data,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire  signed [gdh_pkg::COORD_WIDTH-1:0] first_x,
    input  wire  signed [gdh_pkg::COORD_WIDTH-1:0] first_y,
    input  wire  signed [gdh_pkg::COORD_WIDTH-1:0] first_z,
    input  wire  signed [gdh_pkg::COORD_WIDTH-1:0] second_x,
    input  wire  signed [gdh_pkg::COORD_WIDTH-1:0] second_y,
    input  wire  signed [gdh_pkg::COORD_WIDTH-1:0] second_z,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic        [gdh_pkg::DIST_WIDTH-1:0]  distance
);
    import gdh_pkg::*;

    metric_t                metric_mode_reg;
    logic                   out_valid_reg;
    metric_t                out_mode_reg;
    logic [DIST_WIDTH-1:0]  distance_reg;
    logic [DIST_WIDTH-1:0]  distance_next;
    logic                   en;
    point_t                 first_pt;
    point_t                 second_pt;
    front_beat_t            front_beat;
    root_beat_t             root_beat;

    // pipeline advances unless a result is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign first_pt  = {first_z, first_y, first_x};
    assign second_pt = {second_z, second_y, second_x};

    // metric register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            metric_mode_reg <= METRIC_EUCLID;
        else if (cfg_wr_en)
            metric_mode_reg <= metric_t'(cfg_wr_data);
    end

    gdh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_mode   (metric_mode_reg),
        .first_pt  (first_pt),
        .second_pt (second_pt),
        .beat      (front_beat)
    );

    gdh_root_pipe u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_beat  (front_beat),
        .out_beat (root_beat)
    );

    // metric select
    always_comb
    begin
        unique case (root_beat.mode)
            METRIC_MANHATTAN: distance_next = DIST_WIDTH'(root_beat.sum_abs) << FRAC_BITS;
            METRIC_EUCLID:    distance_next = DIST_WIDTH'(root_beat.root);
            default:          distance_next = DIST_WIDTH'(root_beat.root);
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= root_beat.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            distance_reg <= distance_next;
            out_mode_reg <= root_beat.mode;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    // a Manhattan result has no fraction part
    a_manhattan_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_mode_reg == METRIC_MANHATTAN)
            |-> ((distance_reg & FRAC_MASK) == '0))
        else $error("manhattan distance has fraction bits");

    // a held result stays in the output register
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(distance_reg)))
        else $error("held result lost");

    // the pipe never advances into a held result
    a_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !en)
        else $error("pipeline advanced over a held result");

endmodule
`default_nettype wire
